### hdl/dtdsf_pkg.sv
`default_nettype none
package dtdsf_pkg;
    localparam int MAX_GROUPS = 50;

    typedef struct packed {
        logic [7:0]  row;
        logic [15:0] left_x;
        logic [15:0] right_x;
        logic [31:0] left_depth;
        logic [31:0] right_depth;
        logic [16:0] brightness;
        logic        mark_left_edge;
        logic        mark_right_edge;
    } t_span;

    typedef struct packed {
        logic [7:0] out_row;
        logic [5:0] byte_column;
        logic [7:0] pixel_bits;
        logic [7:0] write_mask;
        logic       last_group;
    } t_group;

    // classified span handed from front to back
    typedef struct packed {
        logic [7:0]  row;
        logic [10:0] xs;
        logic [10:0] xe;
        logic [31:0] zl;
        logic [31:0] zr;
        logic        neg;
        logic [15:0] w;
        logic [15:0] pre;
        logic [16:0] brightness;
        logic        ml;
        logic        mr;
    } t_job;

    function automatic logic [5:0] bayer(input logic [2:0] r, input logic [2:0] c);
        logic [5:0] t;
        unique case ({r, c})
            6'd0: t = 6'd0;   6'd1: t = 6'd32;  6'd2: t = 6'd8;   6'd3: t = 6'd40;
            6'd4: t = 6'd2;   6'd5: t = 6'd34;  6'd6: t = 6'd10;  6'd7: t = 6'd42;
            6'd8: t = 6'd48;  6'd9: t = 6'd16;  6'd10: t = 6'd56; 6'd11: t = 6'd24;
            6'd12: t = 6'd50; 6'd13: t = 6'd18; 6'd14: t = 6'd58; 6'd15: t = 6'd26;
            6'd16: t = 6'd12; 6'd17: t = 6'd44; 6'd18: t = 6'd4;  6'd19: t = 6'd36;
            6'd20: t = 6'd14; 6'd21: t = 6'd46; 6'd22: t = 6'd6;  6'd23: t = 6'd38;
            6'd24: t = 6'd60; 6'd25: t = 6'd28; 6'd26: t = 6'd52; 6'd27: t = 6'd20;
            6'd28: t = 6'd62; 6'd29: t = 6'd30; 6'd30: t = 6'd54; 6'd31: t = 6'd22;
            6'd32: t = 6'd3;  6'd33: t = 6'd35; 6'd34: t = 6'd11; 6'd35: t = 6'd43;
            6'd36: t = 6'd1;  6'd37: t = 6'd33; 6'd38: t = 6'd9;  6'd39: t = 6'd41;
            6'd40: t = 6'd51; 6'd41: t = 6'd19; 6'd42: t = 6'd59; 6'd43: t = 6'd27;
            6'd44: t = 6'd49; 6'd45: t = 6'd17; 6'd46: t = 6'd57; 6'd47: t = 6'd25;
            6'd48: t = 6'd15; 6'd49: t = 6'd47; 6'd50: t = 6'd7;  6'd51: t = 6'd39;
            6'd52: t = 6'd13; 6'd53: t = 6'd45; 6'd54: t = 6'd5;  6'd55: t = 6'd37;
            6'd56: t = 6'd63; 6'd57: t = 6'd31; 6'd58: t = 6'd55; 6'd59: t = 6'd23;
            6'd60: t = 6'd61; 6'd61: t = 6'd29; 6'd62: t = 6'd53; 6'd63: t = 6'd21;
            default: t = 6'd0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

### hdl/dtdsf_if.sv
`default_nettype none
interface dtdsf_span_if;
    import dtdsf_pkg::*;
    logic  valid;
    logic  ready;
    t_span data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dtdsf_group_if;
    import dtdsf_pkg::*;
    logic   valid;
    logic   ready;
    t_group data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/dtdsf_front.sv
`default_nettype none
module dtdsf_front
    import dtdsf_pkg::*;
#(
    parameter int SCREEN_W = 400,
    parameter int SCREEN_H = 240
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtdsf_span_if.sink i_span,
    output logic      o_job_valid,
    output t_job      o_job,
    input  wire logic i_job_ready
);
    // swap, clip and cull; one registered job slot
    t_span s;
    logic signed [15:0] xl, xr;
    logic [31:0] zl, zr;
    logic ml, mr;
    logic signed [17:0] xs_f, xe_f, xs_c, xe_c;
    logic [16:0] w;
    logic keep;
    logic signed [21:0] pre_f;
    logic       r_valid;
    t_job       r_job;

    always_comb begin
        s = i_span.data;
        if ($signed(s.left_x) > $signed(s.right_x)) begin
            xl = s.right_x; xr = s.left_x; zl = s.right_depth; zr = s.left_depth;
            ml = s.mark_right_edge; mr = s.mark_left_edge;
        end else begin
            xl = s.left_x; xr = s.right_x; zl = s.left_depth; zr = s.right_depth;
            ml = s.mark_left_edge; mr = s.mark_right_edge;
        end
        xs_f = (18'(xl) + 18'sd15) >>> 4;
        xe_f = 18'(xr) >>> 4;
        xs_c = (xs_f < 0) ? 18'sd0 : xs_f;
        xe_c = (xe_f > 18'(SCREEN_W - 1)) ? 18'(SCREEN_W - 1) : xe_f;
        w = 17'(18'(xr) - 18'(xl));
        // up to 32768 when the left end is clipped at the screen edge
        pre_f = 22'(xs_c) * 22'sd16 - 22'(xl);
        keep = (32'(s.row) < 32'(SCREEN_H)) && (xs_c <= xe_c) && (w != 17'd0);
    end

    assign i_span.ready = !r_valid || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_span.ready) begin
            r_valid <= i_span.valid && keep;
        end
        if (i_span.ready) begin
            r_job.row        <= s.row;
            r_job.xs         <= 11'(xs_c);
            r_job.xe         <= 11'(xe_c);
            r_job.zl         <= zl;
            r_job.zr         <= zr;
            r_job.neg        <= zr < zl;
            r_job.w          <= w[15:0];
            r_job.pre        <= 16'(pre_f);
            r_job.brightness <= s.brightness;
            r_job.ml         <= ml;
            r_job.mr         <= mr;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;
endmodule
`default_nettype wire

### hdl/dtdsf_queue.sv
`default_nettype none
module dtdsf_queue
    import dtdsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_job      i_job,
    output logic      o_ready,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_ready
);
    // two-entry fifo
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

### hdl/dtdsf_back.sv
`default_nettype none
module dtdsf_back
    import dtdsf_pkg::*;
#(
    parameter int SCREEN_W = 400,
    parameter int SCREEN_H = 240
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  t_job      i_job,
    output logic      o_job_ready,
    dtdsf_group_if.source o_group
);
    localparam int DEPTH = SCREEN_W * SCREEN_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = 11;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_RD    = 8'b0001_0000,
        ST_TEST  = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_WAIT  = 8'b1000_0000
    } t_state;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    t_state      r_st;
    t_job        r_j;
    logic [AW-1:0] r_clr;
    logic [52:0] r_rem;
    logic [52:0] r_quo;
    logic [5:0]  r_bit;
    logic [52:0] r_dz;
    logic signed [66:0] r_acc;
    logic [XW-1:0] r_x;
    logic [7:0]  r_bits, r_mask;
    logic [5:0]  r_count;
    logic        r_ov;
    t_group      r_out;

    logic [31:0] mag;
    logic [51:0] num;
    logic [52:0] rem_sh, wide_w;
    logic [AW-1:0] addr;
    logic [31:0] d;
    logic [2:0]  bx;
    logic        pass, edge_px, white, end_px, grp_end;
    logic [7:0]  bitsel, nbits, nmask;
    logic [57:0] off;
    logic signed [66:0] acc0;

    assign mag    = r_j.neg ? (r_j.zl - r_j.zr) : (r_j.zr - r_j.zl);
    assign num    = {mag, 20'd0};
    assign wide_w = 53'(r_j.w);
    // bring down the next dividend bit, msb first
    assign rem_sh = {r_rem[51:0], num[6'd51 - r_bit]};
    assign addr   = AW'(32'(r_j.row) * 32'(SCREEN_W)) + AW'(r_x);
    assign bx     = r_x[2:0];
    always_comb begin
        if (r_acc < 0) d = 32'd0;
        else if ((r_acc >>> 16) > 67'sh0FFFFFFFF) d = 32'hFFFF_FFFF;
        else d = r_acc[47:16];
        pass    = d > r_rdata;
        end_px  = r_x == r_j.xe;
        edge_px = (r_x == r_j.xs && r_j.ml) || (end_px && r_j.mr);
        white   = !edge_px &&
                  (r_j.brightness > 17'({bayer(r_j.row[2:0], bx), 10'd0}));
        bitsel  = 8'h80 >> bx;
        nbits   = r_bits | ((pass && white) ? bitsel : 8'd0);
        nmask   = r_mask | (pass ? bitsel : 8'd0);
        grp_end = bx == 3'd7 || end_px;
        off     = 58'((r_quo * 53'(r_j.pre)) >> 4);
        acc0    = r_j.neg ? ($signed({3'd0, r_j.zl, 32'd0}) >>> 16) - $signed(67'(off))
                          : ($signed({3'd0, r_j.zl, 32'd0}) >>> 16) + $signed(67'(off));
    end

    assign o_job_ready   = r_st == ST_IDLE;
    assign o_group.valid = r_st == ST_WAIT;
    assign o_group.data  = r_out;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[addr];
        if (r_st == ST_CLEAR) r_mem[r_clr] <= 32'd0;
        else if (r_st == ST_TEST && pass) r_mem[addr] <= d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0;
        end else begin
            unique case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_st <= ST_IDLE;
                end
                ST_IDLE: if (i_job_valid) begin
                    r_j <= i_job; r_rem <= '0; r_quo <= '0; r_bit <= '0;
                    r_st <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division of mag*2^20 by w, msb first
                    if (rem_sh >= wide_w) begin
                        r_rem <= rem_sh - wide_w; r_quo <= {r_quo[51:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh; r_quo <= {r_quo[51:0], 1'b0};
                    end
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd51) r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_dz <= r_quo; r_acc <= acc0; r_x <= r_j.xs;
                    r_bits <= '0; r_mask <= '0; r_count <= '0; r_ov <= 1'b0;
                    r_st <= ST_RD;
                end
                ST_RD: r_st <= ST_TEST;
                ST_TEST: begin
                    r_acc <= r_j.neg ? r_acc - $signed(67'(r_dz)) : r_acc + $signed(67'(r_dz));
                    if (grp_end) begin
                        r_out.out_row <= r_j.row;
                        r_out.byte_column <= 6'(r_x >> 3);
                        r_out.pixel_bits <= nbits;
                        r_out.write_mask <= nmask;
                        r_out.last_group <= end_px ||
                                            (r_count == 6'(MAX_GROUPS - 1));
                        r_bits <= '0; r_mask <= '0;
                        r_st <= r_ov ? (end_px ? ST_IDLE : ST_EMIT) : ST_WAIT;
                    end else begin
                        r_bits <= nbits; r_mask <= nmask;
                        r_x <= r_x + XW'(1); r_st <= ST_RD;
                    end
                end
                ST_WAIT: if (o_group.ready) begin
                    r_count <= r_count + 6'd1;
                    if (r_count == 6'(MAX_GROUPS - 1)) r_ov <= 1'b1;
                    r_st <= r_out.last_group && (r_x == r_j.xe) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    r_x <= r_x + XW'(1); r_st <= ST_RD;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/depth_tested_dithered_span_fill.sv
`default_nettype none
// channel  | dir | payload
// i_span   | in  | row, x ends, depth ends, brightness, edge marks
// o_group  | out | row, byte column, pixel bits, write mask, last group
// after reset a clearing pass zeroes the depth memory
// per span: serial division, a setup step, then per pixel a read and a test-and-write
// on the depth memory read/write port, plus a handoff for each reported group
// the front classifies the next spans into a two-entry queue while the back works
// output holds until taken; culled spans give no group
module depth_tested_dithered_span_fill
    import dtdsf_pkg::*;
#(
    parameter int SCREEN_W = 400,
    parameter int SCREEN_H = 240
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtdsf_span_if.sink    i_span,
    dtdsf_group_if.source o_group
);
    logic f_valid, q_ready, q_valid, b_ready;
    t_job f_job, q_job;

    dtdsf_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
        .i_clk, .i_rst_n, .i_span,
        .o_job_valid(f_valid), .o_job(f_job), .i_job_ready(q_ready));

    dtdsf_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_job(f_job), .o_ready(q_ready),
        .o_valid(q_valid), .o_job(q_job), .i_ready(b_ready));

    dtdsf_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job),
        .o_job_ready(b_ready), .o_group);
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import dtdsf_pkg::*;

    localparam int SCREEN_W = 400;
    localparam int SCREEN_H = 240;
    localparam int N_DIRECTED = 16;

    logic i_clk;
    logic i_rst_n;

    dtdsf_span_if  span_ch();
    dtdsf_group_if group_ch();

    depth_tested_dithered_span_fill #(
        .SCREEN_W(SCREEN_W),
        .SCREEN_H(SCREEN_H)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_span (span_ch.sink),
        .o_group(group_ch.source)
    );

    // predictor state
    logic [31:0] z_mirror [SCREEN_W * SCREEN_H];
    t_group      groups_due[$];
    int          n_fail;
    int          n_pushed;
    bit          drive_done;

    // directed spans, with hand-read first group where obvious
    t_span  dir_span [N_DIRECTED];
    t_group dir_first[N_DIRECTED];
    bit     dir_known[N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // dither threshold by row mod 8 and column within the byte; bayer table typed here
    function automatic logic [5:0] dither_level(input int r, input int c);
        logic [5:0] tbl [64];
        tbl = '{0, 32, 8, 40, 2, 34, 10, 42, 48, 16, 56, 24, 50, 18, 58, 26,
                12, 44, 4, 36, 14, 46, 6, 38, 60, 28, 52, 20, 62, 30, 54, 22,
                3, 35, 11, 43, 1, 33, 9, 41, 51, 19, 59, 27, 49, 17, 57, 25,
                15, 47, 7, 39, 13, 45, 5, 37, 63, 31, 55, 23, 61, 29, 53, 21};
        return tbl[(r % 8) * 8 + c];
    endfunction

    task automatic fill_span_groups(input t_span s);
        int          xl, xr, xs, xe, w, x, n, bx, row;
        logic [31:0] zl, zr, d;
        logic        ml, mr, neg, edge_px;
        longint      diff, acc, dz;
        logic [63:0] mag, dzmag, off;
        logic [7:0]  bits, msk;
        t_group      g;
        row = int'(s.row);
        xl = int'($signed(s.left_x));
        xr = int'($signed(s.right_x));
        zl = s.left_depth;
        zr = s.right_depth;
        ml = s.mark_left_edge;
        mr = s.mark_right_edge;
        n = 0;
        bits = '0;
        msk = '0;
        if (xl > xr) begin
            {xl, xr} = {xr, xl};
            {zl, zr} = {zr, zl};
            {ml, mr} = {mr, ml};
        end
        if (row >= SCREEN_H) return;
        xs = ((xl + 15 + 32768) >> 4) - 2048;
        if (xs < 0) xs = 0;
        xe = ((xr + 32768) >> 4) - 2048;
        if (xe > SCREEN_W - 1) xe = SCREEN_W - 1;
        if (xs > xe) return;
        w = xr - xl;
        if (w <= 0) return;
        diff = longint'(zr) - longint'(zl);
        neg = diff < 0;
        mag = neg ? -diff : diff;
        dzmag = (mag << 20) / 64'(w);
        dz = neg ? -longint'(dzmag) : longint'(dzmag);
        off = (dzmag * 64'(xs * 16 - xl)) >> 4;
        acc = longint'({zl, 16'h0});
        acc = neg ? acc - longint'(off) : acc + longint'(off);
        for (x = xs; x <= xe; x++) begin
            bx = x % 8;
            if (acc < 0) d = '0;
            else if ((acc >>> 16) > 64'hFFFF_FFFF) d = '1;
            else d = acc[47:16];
            if (d > z_mirror[row * SCREEN_W + x]) begin
                z_mirror[row * SCREEN_W + x] = d;
                edge_px = (x == xs && ml) || (x == xe && mr);
                msk[7 - bx] = 1'b1;
                if (!edge_px && 32'(s.brightness) > 32'(dither_level(row, bx)) * 1024)
                    bits[7 - bx] = 1'b1;
            end
            acc += dz;
            if (bx == 7 || x == xe) begin
                if (n < MAX_GROUPS) begin
                    g.out_row = 8'(row);
                    g.byte_column = 6'(x / 8);
                    g.pixel_bits = bits;
                    g.write_mask = msk;
                    g.last_group = (x == xe) || (n == MAX_GROUPS - 1);
                    groups_due.push_back(g);
                    n_pushed++;
                    n++;
                end
                bits = '0;
                msk = '0;
            end
        end
    endtask

    function automatic t_span make_span(input int row, input int xl, input int xr,
                                        input logic [31:0] zl, input logic [31:0] zr,
                                        input int br, input bit ml, input bit mr);
        t_span s;
        s.row = 8'(row);
        s.left_x = 16'(xl);
        s.right_x = 16'(xr);
        s.left_depth = zl;
        s.right_depth = zr;
        s.brightness = 17'(br);
        s.mark_left_edge = ml;
        s.mark_right_edge = mr;
        return s;
    endfunction

    function automatic t_span random_span();
        t_span s;
        int    xl, len;
        s = '0;
        case ($urandom_range(0, 9))
            0: begin
                s.row = 8'($urandom);
                s.left_x = 16'($urandom);
                s.right_x = 16'($urandom);
            end
            1: begin
                s.row = 8'($urandom_range(0, SCREEN_H - 1));
                s.left_x = 16'($urandom_range(0, 16 * 60));
                s.right_x = s.left_x;
            end
            default: begin
                s.row = 8'($urandom_range(0, 9) == 0 ? $urandom_range(232, 239)
                                                     : $urandom_range(0, 15));
                len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 7000)
                                                : $urandom_range(1, 400);
                xl = $urandom_range(0, 7) == 0 ? -int'($urandom_range(0, 300))
                                               : $urandom_range(0, 6400);
                s.left_x = 16'(xl);
                s.right_x = 16'(xl + len);
                if ($urandom_range(0, 1)) {s.left_x, s.right_x} = {s.right_x, s.left_x};
            end
        endcase
        s.left_depth = $urandom;
        s.right_depth = $urandom_range(0, 3) == 0 ? s.left_depth : $urandom;
        s.brightness = $urandom_range(0, 9) == 0 ? 17'h1FFFF
                                                 : 17'($urandom_range(0, 65536));
        s.mark_left_edge = 1'($urandom);
        s.mark_right_edge = 1'($urandom);
        return s;
    endfunction

    task automatic send_span(input t_span s);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0) begin
            span_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        span_ch.data  <= s;
        span_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!span_ch.ready);
        fill_span_groups(s);
    endtask

    // output side: random stall, compare against oldest expected group
    initial begin
        t_group want;
        group_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 40) == 0) begin
                group_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
                group_ch.ready <= 1'b1;
            end else begin
                group_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            @(posedge i_clk);
            if (group_ch.valid && group_ch.ready) begin
                if (groups_due.size() == 0) begin
                    $display("%0t unexpected group: expected none, actual %p",
                             $time, group_ch.data);
                    n_fail++;
                end else begin
                    want = groups_due.pop_front();
                    if (group_ch.data !== want) begin
                        $display("%0t group: expected %p, actual %p",
                                 $time, want, group_ch.data);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        int k, dir_i;
        t_span s;
        n_fail = 0;
        n_pushed = 0;
        drive_done = 0;
        foreach (z_mirror[i]) z_mirror[i] = '0;
        span_ch.valid = 1'b0;
        span_ch.data  = '0;
        i_rst_n = 1'b0;
        dir_known = '{default: 0};
        dir_span[0]  = make_span(0, 0, 16 * 7, 32'h0100_0000, 32'h0100_0000, 65536, 0, 0);
        dir_first[0] = '{out_row: 0, byte_column: 0, pixel_bits: 8'hFF,
                         write_mask: 8'hFF, last_group: 1};
        dir_known[0] = 1;
        dir_span[1]  = make_span(0, 0, 16 * 7, 32'h0200_0000, 32'h0200_0000, 0, 1, 1);
        dir_first[1] = '{out_row: 0, byte_column: 0, pixel_bits: 8'h00,
                         write_mask: 8'hFF, last_group: 1};
        dir_known[1] = 1;
        // far span behind the stored depth: written mask zero
        dir_span[2]  = make_span(0, 0, 16 * 7, 32'h0000_0001, 32'h0000_0001, 65536, 0, 0);
        dir_first[2] = '{out_row: 0, byte_column: 0, pixel_bits: 8'h00,
                         write_mask: 8'h00, last_group: 1};
        dir_known[2] = 1;
        dir_span[3]  = make_span(239, -32768, 32767, 32'hFFFF_FFFF, 0, 65536, 1, 1);
        dir_span[4]  = make_span(1, 32767, -32768, 0, 32'hFFFF_FFFF, 17'h1FFFF, 1, 0);
        dir_span[5]  = make_span(240, 0, 800, 32'hFF, 32'hFF, 100, 0, 0);
        dir_span[6]  = make_span(255, 0, 800, 32'hFF, 32'hFF, 100, 0, 0);
        dir_span[7]  = make_span(2, 80, 80, 32'hFF, 32'hFF, 100, 0, 0);
        dir_span[8]  = make_span(2, 81, 94, 32'hFF, 32'hFF, 100, 0, 0);
        dir_span[9]  = make_span(3, -200, -16, 32'hFF, 32'hFF, 100, 1, 1);
        dir_span[10] = make_span(3, 16 * 400, 16 * 500, 32'hFF, 32'hFF, 100, 1, 1);
        dir_span[11] = make_span(4, 16 * 399, 16 * 399 + 1, 32'h10, 32'h20, 65535, 1, 1);
        dir_span[12] = make_span(5, 17, 16 * 390 + 9, 32'h0000_1000, 32'hFFFF_0000,
                                 32768, 0, 1);
        dir_span[13] = make_span(6, 3, 16 * 30 + 5, 32'hFFFF_0000, 32'h10, 1, 1, 0);
        dir_span[14] = make_span(7, -5, 16 * 63, 32'h0800_0000, 32'h0400_0000, 40000, 0, 0);
        dir_span[15] = make_span(5, 0, 16 * 399, 32'h8000_0000, 32'h8000_0000, 1024, 0, 0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (dir_i = 0; dir_i < N_DIRECTED; dir_i++) begin
            k = n_pushed;
            send_span(dir_span[dir_i]);
            if (dir_known[dir_i] &&
                (n_pushed != k + 1 || groups_due[$] !== dir_first[dir_i])) begin
                $display("%0t directed span %0d: expected %p, actual %p",
                         $time, dir_i, dir_first[dir_i], groups_due[$]);
                n_fail++;
            end
        end
        for (k = 0; k < 200; k++) begin
            if (k == 100) begin
                // hold off until the block has drained
                span_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (groups_due.size() != 0) @(posedge i_clk);
            end
            s = random_span();
            send_span(s);
        end
        span_ch.valid <= 1'b0;
        drive_done = 1;
    end

    initial begin
        wait (drive_done);
        while (groups_due.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (n_fail == 0 && groups_due.size() == 0) begin
            $display("depth_tested_dithered_span_fill: match");
        end else begin
            $display("depth_tested_dithered_span_fill: mismatch");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("depth_tested_dithered_span_fill: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
